[src/cbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_pkg
// Shared constants, codes and control types of the cubic Bezier smoother.
// ----------------------------------------------------------------------------
package cbps_pkg;

  localparam int unsigned COORD_W         = 32;
  localparam int unsigned SUB_W           = 6;
  localparam int unsigned MAX_SUBDIVISION = 63;
  localparam int unsigned SUB_RESET       = 20;
  localparam int unsigned DIV_STEPS       = 18;
  localparam int unsigned MSTEP_W         = 4;

  localparam logic CFG_SUBDIVISION = 1'b0;
  localparam logic CFG_THIN_MODE   = 1'b1;

  // multiply sequence steps
  localparam logic [MSTEP_W-1:0] MS_UU  = 4'd0;
  localparam logic [MSTEP_W-1:0] MS_TT  = 4'd1;
  localparam logic [MSTEP_W-1:0] MS_W0  = 4'd2;
  localparam logic [MSTEP_W-1:0] MS_W1  = 4'd3;
  localparam logic [MSTEP_W-1:0] MS_W2  = 4'd4;
  localparam logic [MSTEP_W-1:0] MS_X0  = 4'd5;
  localparam logic [MSTEP_W-1:0] MS_X1  = 4'd6;
  localparam logic [MSTEP_W-1:0] MS_X2  = 4'd7;
  localparam logic [MSTEP_W-1:0] MS_X3  = 4'd8;
  localparam logic [MSTEP_W-1:0] MS_Y0  = 4'd9;
  localparam logic [MSTEP_W-1:0] MS_Y1  = 4'd10;
  localparam logic [MSTEP_W-1:0] MS_Y2  = 4'd11;
  localparam logic [MSTEP_W-1:0] MS_Y3  = 4'd12;
  localparam logic [MSTEP_W-1:0] MS_END = 4'd13;

  typedef enum logic [1:0] {
    OS_IN,
    OS_CP,
    OS_CURVE
  } out_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS,
    S_DIV,
    S_TINIT,
    S_MUL,
    S_EMIT,
    S_NEXT,
    S_TAIL
  } state_e;

  typedef struct packed {
    logic                capture;
    logic                cp_we;
    logic [1:0]          cp_idx;
    logic                seg_from_in;
    logic                seg_from_cp2;
    logic                div_start;
    logic                div_step;
    logic                t_init;
    logic                t_next;
    logic                mstep_en;
    logic [MSTEP_W-1:0]  mstep;
    logic                out_load;
    out_sel_e            out_sel;
    logic [1:0]          out_cp_idx;
    logic                out_last;
  } cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [SUB_W-1:0] n;
    logic             thin;
  } sts_t;

endpackage

[src/cubic_bezier_polyline_smoother.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_polyline_smoother
// Turns a polyline into cubic Bezier curve points, one segment per three points.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_x_i, in_y_i, in_last_i) are taken on in_valid_i with
//   in_stall_o low; in_stall_o is high while an item is being worked on.
//   Output beats leave through a single output register on out_valid_o and
//   are held while out_stall_i is high; the sequencer waits for that
//   register, so a stalled receiver stalls the block.
//   The first point of a line is accepted, then loaded into the output
//   register; a point that closes no segment is only accepted.  A segment-
//   closing point runs a reciprocal division and a set-up step, then for
//   each parameter step j = 1..N of N subdivisions the shared-multiplier
//   products, an output load (skipped for even j in thin mode) and a step,
//   plus tail beats at line end and any receiver stall cycles.
//   Configuration (cfg_idx_i 0: subdivision, 1: thin mode) is written through
//   cfg_we_i; the user must do so only while idle, the block does not check.
//   Reset clears sequencer, output valid; loads subdivision 20, thin mode off.
// ----------------------------------------------------------------------------
module cubic_bezier_polyline_smoother (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [cbps_pkg::SUB_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [cbps_pkg::COORD_W-1:0] in_x_i,
  input  logic signed [cbps_pkg::COORD_W-1:0] in_y_i,
  input  logic                               in_last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [cbps_pkg::COORD_W-1:0] out_x_o,
  output logic signed [cbps_pkg::COORD_W-1:0] out_y_o,
  output logic                               out_last_o
);

  cbps_pkg::cmd_t cmd;
  cbps_pkg::sts_t sts;

  cbps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_last_o  (out_last_o)
  );

endmodule

[src/cbps_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_ctrl
// Sequencer: point bookkeeping, segment stepping and output ordering.
// ----------------------------------------------------------------------------
module cbps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_stall_o,
  input  cbps_pkg::sts_t  sts_i,
  output cbps_pkg::cmd_t  cmd_o
);

  cbps_pkg::state_e state_q, state_d;
  logic [2:0] ps_q, ps_d;
  logic [1:0] phase_q, phase_d;
  logic       last_q, last_d;
  logic       short_q, short_d;
  logic [1:0] tcnt_q, tcnt_d;
  logic [1:0] tk_q, tk_d;
  logic [cbps_pkg::SUB_W-1:0]   j_q, j_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic [cbps_pkg::MSTEP_W-1:0] ms_q, ms_d;

  logic       accept;
  logic [2:0] ps_inc;
  logic [1:0] ph_n;

  assign in_stall_o = (state_q != cbps_pkg::S_IDLE);
  assign accept     = in_valid_i && (state_q == cbps_pkg::S_IDLE);
  assign ps_inc     = (ps_q < 3'd4) ? ps_q + 3'd1 : 3'd4;
  assign ph_n       = phase_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbps_pkg::S_IDLE;
      ps_q    <= '0;
      phase_q <= '0;
      last_q  <= 1'b0;
      short_q <= 1'b0;
      tcnt_q  <= '0;
      tk_q    <= '0;
      j_q     <= '0;
      dcnt_q  <= '0;
      ms_q    <= '0;
    end else begin
      state_q <= state_d;
      ps_q    <= ps_d;
      phase_q <= phase_d;
      last_q  <= last_d;
      short_q <= short_d;
      tcnt_q  <= tcnt_d;
      tk_q    <= tk_d;
      j_q     <= j_d;
      dcnt_q  <= dcnt_d;
      ms_q    <= ms_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ps_d    = ps_q;
    phase_d = phase_q;
    last_d  = last_q;
    short_d = short_q;
    tcnt_d  = tcnt_q;
    tk_d    = tk_q;
    j_d     = j_q;
    dcnt_d  = dcnt_q;
    ms_d    = ms_q;
    cmd_o   = '0;
    cmd_o.out_sel    = cbps_pkg::OS_IN;
    cmd_o.cp_idx     = phase_q;
    cmd_o.mstep      = ms_q;
    cmd_o.out_cp_idx = tk_q;

    unique case (state_q)
      cbps_pkg::S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          last_d        = in_last_i;
          if (ps_q == 3'd0) begin
            cmd_o.seg_from_in = 1'b1;
            phase_d = '0;
            ps_d    = in_last_i ? 3'd0 : 3'd1;
            state_d = cbps_pkg::S_PASS;
          end else begin
            cmd_o.cp_we = 1'b1;
            short_d     = (ps_inc < 3'd4);
            tcnt_d      = ph_n;
            tk_d        = '0;
            ps_d        = ps_inc;
            if (ph_n == 2'd3) begin
              phase_d         = '0;
              dcnt_d          = '0;
              cmd_o.div_start = 1'b1;
              state_d         = cbps_pkg::S_DIV;
            end else begin
              phase_d = ph_n;
              state_d = in_last_i ? cbps_pkg::S_TAIL : cbps_pkg::S_IDLE;
            end
            if (in_last_i) begin
              ps_d    = '0;
              phase_d = '0;
            end
          end
        end
      end
      cbps_pkg::S_PASS: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = cbps_pkg::OS_IN;
          cmd_o.out_last = last_q;
          state_d        = cbps_pkg::S_IDLE;
        end
      end
      cbps_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 5'd1;
        if (dcnt_q == 5'(cbps_pkg::DIV_STEPS - 1)) begin
          state_d = cbps_pkg::S_TINIT;
        end
      end
      cbps_pkg::S_TINIT: begin
        cmd_o.t_init = 1'b1;
        j_d          = cbps_pkg::SUB_W'(1);
        ms_d         = cbps_pkg::MS_UU;
        state_d      = cbps_pkg::S_MUL;
      end
      cbps_pkg::S_MUL: begin
        cmd_o.mstep_en = 1'b1;
        ms_d           = ms_q + 4'd1;
        if (ms_q == cbps_pkg::MS_END) begin
          state_d = cbps_pkg::S_EMIT;
        end
      end
      cbps_pkg::S_EMIT: begin
        if (sts_i.thin && !j_q[0]) begin
          state_d = cbps_pkg::S_NEXT;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = cbps_pkg::OS_CURVE;
          state_d        = cbps_pkg::S_NEXT;
        end
      end
      cbps_pkg::S_NEXT: begin
        if (j_q == sts_i.n) begin
          cmd_o.seg_from_cp2 = 1'b1;
          state_d = last_q ? cbps_pkg::S_TAIL : cbps_pkg::S_IDLE;
        end else begin
          cmd_o.t_next = 1'b1;
          j_d          = j_q + cbps_pkg::SUB_W'(1);
          ms_d         = cbps_pkg::MS_UU;
          state_d      = cbps_pkg::S_MUL;
        end
      end
      cbps_pkg::S_TAIL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (short_q) begin
            cmd_o.out_sel  = cbps_pkg::OS_CP;
            cmd_o.out_last = (tk_q == tcnt_q - 2'd1);
            tk_d           = tk_q + 2'd1;
            if (tk_q == tcnt_q - 2'd1) begin
              state_d = cbps_pkg::S_IDLE;
            end
          end else begin
            cmd_o.out_sel  = cbps_pkg::OS_IN;
            cmd_o.out_last = 1'b1;
            state_d        = cbps_pkg::S_IDLE;
          end
        end
      end
      default: state_d = cbps_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free) else $error("output overwritten");
  a_cp_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cp_we |-> (cmd_o.cp_idx != 2'd3)) else $error("control point index");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbps_pkg::S_DIV) |-> (dcnt_q < 5'(cbps_pkg::DIV_STEPS)))
    else $error("divider overrun");
  a_seg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbps_pkg::S_NEXT && j_q == sts_i.n && !last_q)
    |=> (state_q == cbps_pkg::S_IDLE)) else $error("segment end");
`endif

endmodule

[src/cbps_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_dp
// Datapath: point store, t stepping divider, shared multiplier, output register.
// ----------------------------------------------------------------------------
module cbps_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [cbps_pkg::SUB_W-1:0]  cfg_data_i,
  input  logic signed [cbps_pkg::COORD_W-1:0] in_x_i,
  input  logic signed [cbps_pkg::COORD_W-1:0] in_y_i,
  input  cbps_pkg::cmd_t              cmd_i,
  output cbps_pkg::sts_t              sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [cbps_pkg::COORD_W-1:0] out_x_o,
  output logic signed [cbps_pkg::COORD_W-1:0] out_y_o,
  output logic                        out_last_o
);

  localparam int unsigned CW = cbps_pkg::COORD_W;

  logic [cbps_pkg::SUB_W-1:0] sub_q;
  logic                       thin_q;
  logic [cbps_pkg::SUB_W-1:0] n;
  logic [6:0]                 d;

  logic signed [CW-1:0] inx_q, iny_q, sx_q, sy_q;
  logic signed [CW-1:0] cpx_q [3];
  logic signed [CW-1:0] cpy_q [3];

  logic [7:0]  rem_q, rem_sh;
  logic [17:0] dvd_q, quo_q;
  logic [16:0] t_q, u;
  logic [6:0]  r_q;
  logic [7:0]  s_init, s_next;

  logic signed [33:0] ma;
  logic signed [17:0] mb;
  logic signed [51:0] prod_q, rnd1;
  logic signed [53:0] rnd3;
  logic [32:0] uu_q, tt_q;
  logic [16:0] w0_q, w1_q, w2_q;
  logic signed [17:0] w3_q;
  logic signed [18:0] w3_d;
  logic signed [51:0] accx_q, accy_q;

  logic signed [CW-1:0] cx, cy;
  logic                 out_valid_q, out_last_q;
  logic signed [CW-1:0] out_x_q, out_y_q;
  logic                 out_free;

  function automatic logic signed [31:0] conv(input logic signed [51:0] acc);
    logic signed [52:0] a;
    logic signed [36:0] sh;
    a  = 53'(acc) + 53'sd32768;
    sh = 37'(a >>> 16);
    if (a < -(53'sd1 <<< 47)) begin
      conv = 32'h7FFF_FFFF;
    end else if (sh > 37'sh0_7FFF_FFFF) begin
      conv = 32'h7FFF_FFFF;
    end else if (sh < -37'sh0_8000_0000) begin
      conv = 32'h8000_0000;
    end else begin
      conv = sh[31:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q  <= cbps_pkg::SUB_W'(cbps_pkg::SUB_RESET);
      thin_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbps_pkg::CFG_SUBDIVISION: sub_q  <= cfg_data_i;
        cbps_pkg::CFG_THIN_MODE:   thin_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign n = (sub_q == '0) ? cbps_pkg::SUB_W'(1) :
             (sub_q > cbps_pkg::SUB_W'(cbps_pkg::MAX_SUBDIVISION)) ?
             cbps_pkg::SUB_W'(cbps_pkg::MAX_SUBDIVISION) : sub_q;
  assign d = {n, 1'b0};

  // point store
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      inx_q <= in_x_i;
      iny_q <= in_y_i;
    end
    if (cmd_i.cp_we) begin
      cpx_q[cmd_i.cp_idx] <= in_x_i;
      cpy_q[cmd_i.cp_idx] <= in_y_i;
    end
    if (cmd_i.seg_from_in) begin
      sx_q <= in_x_i;
      sy_q <= in_y_i;
    end else if (cmd_i.seg_from_cp2) begin
      sx_q <= cpx_q[2];
      sy_q <= cpy_q[2];
    end
  end

  // 2^17 / 2n, one quotient bit a cycle; then t stepped by quotient and remainder
  assign rem_sh = {rem_q[6:0], dvd_q[17]};
  assign s_init = {1'b0, quo_q[6:0] & 7'd0} + {1'b0, rem_q[6:0]} + {2'b0, n};
  assign s_next = {1'b0, r_q} + {1'b0, rem_q[6:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= 18'h2_0000;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[16:0], 1'b0};
      if (rem_sh >= {1'b0, d}) begin
        rem_q <= rem_sh - {1'b0, d};
        quo_q <= {quo_q[16:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[16:0], 1'b0};
      end
    end
    if (cmd_i.t_init) begin
      if (s_init >= {1'b0, d}) begin
        t_q <= quo_q[16:0] + 17'd1;
        r_q <= 7'(s_init - {1'b0, d});
      end else begin
        t_q <= quo_q[16:0];
        r_q <= s_init[6:0];
      end
    end else if (cmd_i.t_next) begin
      if (s_next >= {1'b0, d}) begin
        t_q <= t_q + quo_q[16:0] + 17'd1;
        r_q <= 7'(s_next - {1'b0, d});
      end else begin
        t_q <= t_q + quo_q[16:0];
        r_q <= s_next[6:0];
      end
    end
  end

  assign u = 17'h1_0000 - t_q;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.mstep)
      cbps_pkg::MS_UU: begin ma = 34'(u);            mb = 18'(u); end
      cbps_pkg::MS_TT: begin ma = 34'(t_q);          mb = 18'(t_q); end
      cbps_pkg::MS_W0: begin ma = 34'(uu_q);         mb = 18'(u); end
      cbps_pkg::MS_W1: begin ma = 34'(uu_q);         mb = 18'(t_q); end
      cbps_pkg::MS_W2: begin ma = 34'(tt_q);         mb = 18'(u); end
      cbps_pkg::MS_X0: begin ma = 34'(sx_q);         mb = 18'(w0_q); end
      cbps_pkg::MS_X1: begin ma = 34'(cpx_q[0]);     mb = 18'(w1_q); end
      cbps_pkg::MS_X2: begin ma = 34'(cpx_q[1]);     mb = 18'(w2_q); end
      cbps_pkg::MS_X3: begin ma = 34'(cpx_q[2]);     mb = w3_q; end
      cbps_pkg::MS_Y0: begin ma = 34'(sy_q);         mb = 18'(w0_q); end
      cbps_pkg::MS_Y1: begin ma = 34'(cpy_q[0]);     mb = 18'(w1_q); end
      cbps_pkg::MS_Y2: begin ma = 34'(cpy_q[1]);     mb = 18'(w2_q); end
      cbps_pkg::MS_Y3: begin ma = 34'(cpy_q[2]);     mb = w3_q; end
      default: ;
    endcase
  end

  assign rnd1 = prod_q + (52'sd1 <<< 31);
  assign rnd3 = (54'(prod_q) <<< 1) + 54'(prod_q) + (54'sd1 <<< 31);
  assign w3_d = 19'sh1_0000 - 19'(w0_q) - 19'(w1_q) - 19'(w2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mstep_en) begin
      prod_q <= 52'(ma) * 52'(mb);
      case (cmd_i.mstep)
        cbps_pkg::MS_TT: uu_q <= prod_q[32:0];
        cbps_pkg::MS_W0: tt_q <= prod_q[32:0];
        cbps_pkg::MS_W1: w0_q <= rnd1[48:32];
        cbps_pkg::MS_W2: w1_q <= rnd3[48:32];
        cbps_pkg::MS_X0: w2_q <= rnd3[48:32];
        cbps_pkg::MS_X1: begin
          w3_q   <= w3_d[17:0];
          accx_q <= prod_q;
        end
        cbps_pkg::MS_X2, cbps_pkg::MS_X3, cbps_pkg::MS_Y0: accx_q <= accx_q + prod_q;
        cbps_pkg::MS_Y1: accy_q <= prod_q;
        cbps_pkg::MS_Y2, cbps_pkg::MS_Y3, cbps_pkg::MS_END: accy_q <= accy_q + prod_q;
        default: ;
      endcase
    end
  end

  assign cx = conv(accx_q);
  assign cy = conv(accy_q);

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_last_q <= cmd_i.out_last;
      unique case (cmd_i.out_sel)
        cbps_pkg::OS_IN: begin
          out_x_q <= inx_q;
          out_y_q <= iny_q;
        end
        cbps_pkg::OS_CP: begin
          out_x_q <= cpx_q[cmd_i.out_cp_idx];
          out_y_q <= cpy_q[cmd_i.out_cp_idx];
        end
        default: begin
          out_x_q <= cx;
          out_y_q <= cy;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_last_o    = out_last_q;
  assign sts_o.out_free = out_free;
  assign sts_o.n        = n;
  assign sts_o.thin     = thin_q;

`ifndef NO_ASSERTIONS
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n != '0) && (n <= cbps_pkg::SUB_W'(cbps_pkg::MAX_SUBDIVISION)))
    else $error("subdivision out of range");
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mstep_en |-> (t_q <= 17'h1_0000)) else $error("t above one");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.t_next) |-> ({1'b0, r_q} < {1'b0, d})) else $error("t remainder");
`endif

endmodule
